### hdl/sle_pkg.sv
// ----------------------------------------------------------------------------
// Sequential list engine package
// Request codes and sequencer states shared by the list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam logic [1:0] OP_SEARCH = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam int unsigned FieldW = 7;
  localparam int unsigned DataW  = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_INSERT,
    S_REMOVE,
    S_DONE
  } state_e;

endpackage

### hdl/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// Sequential list engine
// Ordered list of signed 32-bit values kept in a one-read, one-write memory.
// ----------------------------------------------------------------------------
// The block holds one request at a time and walks the list memory one entry
// per cycle, using a single read port with a registered read and a single
// write port. A search reads the entries in order and stops at the first
// match. An insert at slot p moves the entries from p up one slot, walking
// down from the top, then writes the new value; an append at the end of the
// list moves nothing. A remove of entry p reads it and each entry above it,
// and each shifted entry is read once and written back one slot over. A
// request that fails its checks goes straight to its result. The result sits
// in an output register, so the next request can be taken while the previous
// result waits; a finished request holds the engine until that register is
// free.
module sequential_list_engine
  import sle_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [FieldW-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               op_i,
  input  logic [FieldW-1:0]        position_i,
  input  logic signed [DataW-1:0]  value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     ok_o,
  output logic [FieldW-1:0]        found_at_o,
  output logic signed [DataW-1:0]  removed_value_o,
  output logic [FieldW-1:0]        count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (LW > FieldW) ? LW : FieldW;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  state_e state_q, state_d;

  logic [FieldW-1:0] cap_q;
  logic [LW-1:0]     len_q, len_d;
  logic [LW-1:0]     pos_q, pos_d;
  logic [DataW-1:0]  val_q, val_d;
  logic [LW-1:0]     rd_ptr_q, rd_ptr_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [LW-1:0]     cmp_idx_q, cmp_idx_d;
  logic              wb_vld_q, wb_vld_d;
  logic              wb_first_q, wb_first_d;
  logic [LW-1:0]     wb_addr_q, wb_addr_d;
  logic              first_q, first_d;
  logic [DataW-1:0]  taken_q, taken_d;
  logic              res_ok_q, res_ok_d;
  logic [FieldW-1:0] res_found_q, res_found_d;
  logic [DataW-1:0]  res_rem_q, res_rem_d;

  logic              out_valid_q, out_valid_d;
  logic              out_ok_q;
  logic [FieldW-1:0] out_found_q;
  logic [DataW-1:0]  out_rem_q;
  logic [FieldW-1:0] out_count_q;
  logic              out_load;

  logic [DataW-1:0]  mem_q [DEPTH];
  logic [DataW-1:0]  rdata_q;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DataW-1:0]  mem_wdata;

  logic              in_fire;
  logic [CW-1:0]     len_ext, pos_ext, cap_ext;
  logic              ins_bad, rem_bad;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;

  assign len_ext = CW'(len_q);
  assign pos_ext = CW'(position_i);
  assign cap_ext = CW'(cap_q);
  assign ins_bad = (pos_ext > len_ext) || (len_ext >= DepthC) || (len_ext >= cap_ext);
  assign rem_bad = (len_q == '0) || (position_i == '0) || (pos_ext > len_ext);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    pos_d       = pos_q;
    val_d       = val_q;
    rd_ptr_d    = rd_ptr_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    wb_vld_d    = 1'b0;
    wb_first_d  = 1'b0;
    wb_addr_d   = wb_addr_q;
    first_d     = first_q;
    taken_d     = taken_q;
    res_ok_d    = res_ok_q;
    res_found_d = res_found_q;
    res_rem_d   = res_rem_q;
    mem_re      = 1'b0;
    mem_raddr   = rd_ptr_q[AW-1:0];
    mem_we      = 1'b0;
    mem_waddr   = wb_addr_q[AW-1:0];
    mem_wdata   = rdata_q;
    out_load    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          pos_d       = LW'(position_i);
          val_d       = value_i;
          res_ok_d    = 1'b0;
          res_found_d = '0;
          res_rem_d   = '0;
          case (op_i)
            OP_SEARCH: begin
              rd_ptr_d = '0;
              state_d  = S_SEARCH;
            end
            OP_INSERT: begin
              rd_ptr_d = len_q;
              state_d  = ins_bad ? S_DONE : S_INSERT;
            end
            OP_REMOVE: begin
              rd_ptr_d = LW'(position_i) - LW'(1);
              first_d  = 1'b1;
              state_d  = rem_bad ? S_DONE : S_REMOVE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SEARCH: begin
        // The compare looks at the entry read in the previous cycle.
        if (cmp_vld_q && (rdata_q == val_q)) begin
          res_ok_d    = 1'b1;
          res_found_d = FieldW'(cmp_idx_q + LW'(1));
          state_d     = S_DONE;
        end else if (rd_ptr_q < len_q) begin
          mem_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_ptr_q;
          rd_ptr_d  = rd_ptr_q + LW'(1);
        end else begin
          state_d = S_DONE;
        end
      end
      S_INSERT: begin
        // Walk down from the top: entry a is read, then written to a + 1.
        if (wb_vld_q) begin
          mem_we = 1'b1;
        end
        if (rd_ptr_q > pos_q) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(rd_ptr_q - LW'(1));
          wb_vld_d  = 1'b1;
          wb_addr_d = rd_ptr_q;
          rd_ptr_d  = rd_ptr_q - LW'(1);
        end else if (!wb_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[AW-1:0];
          mem_wdata = val_q;
          len_d     = len_q + LW'(1);
          res_ok_d  = 1'b1;
          state_d   = S_DONE;
        end
      end
      S_REMOVE: begin
        // Walk up from the removed entry: entry a is read, then written to
        // a - 1. The first beat read is the removed entry itself.
        if (wb_vld_q) begin
          if (wb_first_q) begin
            taken_d = rdata_q;
          end else begin
            mem_we = 1'b1;
          end
        end
        if (rd_ptr_q < len_q) begin
          mem_re     = 1'b1;
          wb_vld_d   = 1'b1;
          wb_first_d = first_q;
          wb_addr_d  = rd_ptr_q - LW'(1);
          rd_ptr_d   = rd_ptr_q + LW'(1);
          first_d    = 1'b0;
        end else if (!wb_vld_q) begin
          len_d     = len_q - LW'(1);
          res_ok_d  = 1'b1;
          res_rem_d = taken_q;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= FieldW'(64);
      len_q       <= '0;
      cmp_vld_q   <= 1'b0;
      wb_vld_q    <= 1'b0;
      wb_first_q  <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      len_q       <= len_d;
      cmp_vld_q   <= cmp_vld_d;
      wb_vld_q    <= wb_vld_d;
      wb_first_q  <= wb_first_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    val_q       <= val_d;
    rd_ptr_q    <= rd_ptr_d;
    cmp_idx_q   <= cmp_idx_d;
    wb_addr_q   <= wb_addr_d;
    taken_q     <= taken_d;
    res_ok_q    <= res_ok_d;
    res_found_q <= res_found_d;
    res_rem_q   <= res_rem_d;
    if (out_load) begin
      out_ok_q    <= res_ok_q;
      out_found_q <= res_found_q;
      out_rem_q   <= res_rem_q;
      out_count_q <= FieldW'(len_q);
    end
  end

  // List store: one write port, one read port with registered data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = out_ok_q;
  assign found_at_o      = out_found_q;
  assign removed_value_o = out_rem_q;
  assign count_o         = out_count_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(len_q) <= DepthC)
    else $error("list length exceeds the store depth");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (found_at_o != '0) |-> ok_o)
    else $error("match position reported without ok");

  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (removed_value_o != '0) |-> ok_o)
    else $error("removed value reported without ok");

  a_search_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (rd_ptr_q <= len_q))
    else $error("search pointer ran past the list length");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Sequential list engine testbench
// Directed and random list requests checked against a queue-based list.
// ----------------------------------------------------------------------------
// Every accepted request is applied to a local copy of the list, and the
// expected result is queued. Each result beat is compared field by field with
// the oldest queued result. Both handshakes idle at random. The capacity
// register is rewritten between phases while the engine is idle.
module tb_top;
  import sle_pkg::*;

  localparam int unsigned ListDepth     = 64;
  localparam int unsigned WatchdogLimit = 1000;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  localparam logic signed [DataW-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] ValMax = 32'sh7fff_ffff;

  typedef struct packed {
    logic                    ok;
    logic [FieldW-1:0]       found_at;
    logic signed [DataW-1:0] removed_value;
    logic [FieldW-1:0]       count;
  } list_result_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [FieldW-1:0]       cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              op_i        = OP_SEARCH;
  logic [FieldW-1:0]       position_i  = '0;
  logic signed [DataW-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    ok_o;
  logic [FieldW-1:0]       found_at_o;
  logic signed [DataW-1:0] removed_value_o;
  logic [FieldW-1:0]       count_o;

  logic signed [DataW-1:0] list_entries[$];
  logic [FieldW-1:0]       capacity_setting = 7'd64;
  list_result_t            pending_results[$];
  int unsigned             fail_count   = 0;
  int unsigned             quiet_cycles = 0;
  bit                      idle_gaps_on = 1'b1;

  sequential_list_engine #(
    .DEPTH(ListDepth)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ok_o           (ok_o),
    .found_at_o     (found_at_o),
    .removed_value_o(removed_value_o),
    .count_o        (count_o)
  );

  initial begin : clock_gen
    forever #4 clk_i = ~clk_i;
  end

  // Applies one request to the local list and returns what the engine owes.
  function automatic list_result_t apply_request(input logic [1:0] op,
                                                 input logic [FieldW-1:0] pos,
                                                 input logic signed [DataW-1:0] val);
    list_result_t res;
    int unsigned  len;
    int unsigned  limit;
    bit           hit;
    res   = '0;
    len   = list_entries.size();
    limit = (capacity_setting < ListDepth) ? capacity_setting : ListDepth;
    hit   = 1'b0;
    case (op)
      OP_SEARCH: begin
        for (int k = 0; k < len; k++) begin
          if (!hit && list_entries[k] == val) begin
            hit          = 1'b1;
            res.ok       = 1'b1;
            res.found_at = FieldW'(k + 1);
          end
        end
      end
      OP_INSERT: begin
        if (pos <= len && len < limit) begin
          list_entries.insert(pos, val);
          res.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos >= 1 && pos <= len) begin
          res.removed_value = list_entries[pos - 1];
          list_entries.delete(pos - 1);
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = FieldW'(list_entries.size());
    return res;
  endfunction

  function automatic int unsigned draw_wait();
    return idle_gaps_on ? $urandom_range(0, 14) : 0;
  endfunction

  // Mostly values already in the list or from a tiny pool, so searches hit
  // and duplicates appear; the rest are extremes and full-range values.
  function automatic logic signed [DataW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3 && list_entries.size() != 0)
      return list_entries[$urandom_range(0, list_entries.size() - 1)];
    if (r < 6)
      return $urandom_range(0, 7) - 4;
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0:       return ValMin;
        1:       return ValMax;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [FieldW-1:0] pos,
                              input logic signed [DataW-1:0] val);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_request(op, pos, val));
  endtask

  // Holds off new requests until every outstanding result has been seen.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [FieldW-1:0] cap);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i         <= 1'b0;
    capacity_setting  = cap;
  endtask

  task automatic test_empty_list();
    send_request(OP_SEARCH, 7'd0, 32'sd5);
    send_request(OP_REMOVE, 7'd1, '0);
    send_request(OP_REMOVE, 7'd0, '0);
    send_request(OP_INSERT, 7'd1, 32'sd9);
    send_request(OP_INSERT, 7'd127, 32'sd9);
    send_request(OP_UNUSED, 7'd0, '0);
  endtask

  task automatic test_list_edits();
    send_request(OP_INSERT, 7'd0, ValMax);
    send_request(OP_INSERT, 7'd0, ValMin);
    send_request(OP_INSERT, 7'd2, -1);
    send_request(OP_INSERT, 7'd1, '0);
    send_request(OP_INSERT, 7'd4, ValMin);
    // Two equal entries: the search must report the first one.
    send_request(OP_SEARCH, 7'd127, ValMin);
    send_request(OP_SEARCH, 7'd0, -1);
    send_request(OP_SEARCH, 7'd0, 32'sd12345);
    send_request(OP_REMOVE, 7'd0, '0);
    send_request(OP_REMOVE, 7'd6, '0);
    send_request(OP_REMOVE, 7'd127, '0);
    send_request(OP_INSERT, 7'd7, 32'sd1);
    send_request(OP_REMOVE, 7'd3, '0);
    send_request(OP_REMOVE, 7'd4, '0);
    send_request(OP_UNUSED, 7'd127, ValMax);
  endtask

  task automatic test_capacity_limits();
    // Capacity drops below the current length, so inserts must fail until removes bring the length below it.
    write_capacity(7'd2);
    send_request(OP_INSERT, 7'd0, 32'sd3);
    send_request(OP_REMOVE, 7'd1, '0);
    send_request(OP_INSERT, 7'd0, 32'sd3);
    send_request(OP_REMOVE, 7'd1, '0);
    send_request(OP_INSERT, 7'd1, 32'sd7);
    send_request(OP_INSERT, 7'd0, 32'sd8);
    write_capacity(7'd0);
    send_request(OP_INSERT, 7'd0, 32'sd8);
    send_request(OP_SEARCH, 7'd0, 32'sd7);
  endtask

  task automatic test_full_depth();
    // A capacity above the store size must behave as the store size.
    write_capacity(7'd127);
    while (list_entries.size() < ListDepth)
      send_request(OP_INSERT, FieldW'($urandom_range(0, list_entries.size())),
                   pick_value());
    send_request(OP_INSERT, 7'd0, 32'sd1);
    send_request(OP_INSERT, 7'd64, 32'sd1);
    send_request(OP_SEARCH, 7'd0, list_entries[ListDepth - 1]);
    send_request(OP_REMOVE, 7'd64, '0);
    send_request(OP_REMOVE, 7'd1, '0);
  endtask

  task automatic run_random_requests(input int unsigned n, input int unsigned target_len);
    int unsigned len;
    int unsigned r;
    logic [1:0]  op;
    logic [FieldW-1:0] pos;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0)
        idle_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 60) == 0)
        wait_for_results();
      len = list_entries.size();
      r   = $urandom_range(0, 99);
      if (r < 3)
        op = OP_UNUSED;
      else if (r < 35)
        op = OP_SEARCH;
      else if ($urandom_range(0, 2 * target_len + 1) >= len)
        op = OP_INSERT;
      else
        op = OP_REMOVE;
      if ($urandom_range(0, 9) == 0)
        pos = FieldW'($urandom_range(0, 127));
      else if (op == OP_INSERT)
        pos = FieldW'($urandom_range(0, len));
      else if (op == OP_REMOVE)
        pos = (len == 0) ? FieldW'($urandom_range(0, 1)) : FieldW'($urandom_range(1, len));
      else
        pos = FieldW'($urandom_range(0, 127));
      send_request(op, pos, pick_value());
    end
  endtask

  task automatic test_random_traffic();
    write_capacity(7'd64);
    run_random_requests(100, 40);
    write_capacity(7'd127);
    run_random_requests(100, 60);
    write_capacity(7'd10);
    run_random_requests(100, 8);
    write_capacity(7'd1);
    run_random_requests(60, 1);
    write_capacity(7'd0);
    run_random_requests(40, 0);
    write_capacity(7'd33);
    run_random_requests(100, 20);
    write_capacity(7'd64);
    run_random_requests(60, 30);
  endtask

  initial begin : result_sink
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (ok_o !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, ok_o);
          fail_count++;
        end
        if (found_at_o !== want.found_at) begin
          $error("found_at: expected %0d, actual %0d", want.found_at, found_at_o);
          fail_count++;
        end
        if (removed_value_o !== want.removed_value) begin
          $error("removed_value: expected %0d, actual %0d",
                 $signed(want.removed_value), removed_value_o);
          fail_count++;
        end
        if (count_o !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, count_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : test_sequence
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_list_edits();
    test_capacity_limits();
    test_full_depth();
    test_random_traffic();
    wait_for_results();
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/sle_pkg.sv
hdl/sequential_list_engine.sv
bench/tb_top.sv
